FILE: hdl/sglr_pkg.sv
// Shared types and constants for the skewed Gauss lattice reduction block.
package sglr_pkg;

  // Shared multiplier operand and product widths.
  localparam int unsigned MUL_W  = 32;
  localparam int unsigned PROD_W = 2 * MUL_W;

  // Width and reset value of the skew weight register.
  localparam int unsigned WEIGHT_W = 32;
  localparam logic [WEIGHT_W-1:0] SKEW_RESET = 32'd4096;

  // Status of the rounding divider, sent to the sequencer.
  typedef struct packed {
    logic done;
    logic ovf;
  } div_stat_t;

endpackage

FILE: hdl/sglr_mul.sv
// Shared registered multiplier used for all products of the reduction.
module sglr_mul (
  input  logic                         clk_i,
  input  logic [sglr_pkg::MUL_W-1:0]   op_a_i,
  input  logic [sglr_pkg::MUL_W-1:0]   op_b_i,
  output logic [sglr_pkg::PROD_W-1:0]  prod_o
);
  import sglr_pkg::*;

  logic [PROD_W-1:0] prod_q;

  // One unsigned product per cycle, registered and ready in the next cycle.
  always_ff @(posedge clk_i) begin
    prod_q <= PROD_W'(op_a_i) * PROD_W'(op_b_i);
  end

  assign prod_o = prod_q;

endmodule

FILE: hdl/sglr_div.sv
// Bit-serial divider that rounds a signed numerator over an unsigned divisor.
module sglr_div #(
  parameter int unsigned CW = 32,
  parameter int unsigned NW = 97
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [NW-1:0]           num_i,
  input  logic [NW-1:0]           den_i,
  output sglr_pkg::div_stat_t     stat_o,
  output logic signed [CW-1:0]    quot_o
);
  import sglr_pkg::*;

  localparam int unsigned CNT_W = $clog2(NW);

  typedef enum logic [1:0] {
    D_IDLE,
    D_RUN,
    D_ROUND
  } dstate_e;

  dstate_e           state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              done_q, done_d;
  logic              ovf_q, ovf_d;
  logic              negv_q, negv_d;
  logic [NW-1:0]     m_q, m_d;
  logic [NW-1:0]     r_q, r_d;
  logic [NW-1:0]     q_q, q_d;
  logic [NW-1:0]     den_q, den_d;
  logic signed [CW-1:0] quot_q, quot_d;

  logic [NW-1:0]     r_sh;
  logic [NW-1:0]     r_twice;
  logic              inc;
  logic [NW:0]       q_r;
  logic [NW:0]       lim;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    ovf_d   = ovf_q;
    negv_d  = negv_q;
    m_d     = m_q;
    r_d     = r_q;
    q_d     = q_q;
    den_d   = den_q;
    quot_d  = quot_q;

    // One quotient bit per cycle; the remainder stays below the divisor.
    r_sh    = {r_q[NW-2:0], m_q[NW-1]};
    // Rounding: compare twice the remainder with the divisor, ties to even.
    r_twice = {r_q[NW-2:0], 1'b0};
    inc     = (r_twice > den_q) || ((r_twice == den_q) && q_q[0]);
    q_r     = (NW+1)'(q_q) + (NW+1)'(inc);
    lim     = ((NW+1)'(1) << (CW - 1)) - (negv_q ? '0 : (NW+1)'(1));

    unique case (state_q)
      D_IDLE: begin
        if (start_i) begin
          negv_d  = num_i[NW-1];
          m_d     = num_i[NW-1] ? (~num_i + 1'b1) : num_i;
          r_d     = '0;
          q_d     = '0;
          den_d   = den_i;
          cnt_d   = '0;
          state_d = D_RUN;
        end
      end
      D_RUN: begin
        m_d = {m_q[NW-2:0], 1'b0};
        if (r_sh >= den_q) begin
          r_d = r_sh - den_q;
          q_d = {q_q[NW-2:0], 1'b1};
        end else begin
          r_d = r_sh;
          q_d = {q_q[NW-2:0], 1'b0};
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(NW - 1)) begin
          state_d = D_ROUND;
        end
      end
      D_ROUND: begin
        ovf_d   = q_r > lim;
        quot_d  = negv_q ? (~q_r[CW-1:0] + 1'b1) : q_r[CW-1:0];
        done_d  = 1'b1;
        state_d = D_IDLE;
      end
      default: state_d = D_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= D_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    ovf_q  <= ovf_d;
    negv_q <= negv_d;
    m_q    <= m_d;
    r_q    <= r_d;
    q_q    <= q_d;
    den_q  <= den_d;
    quot_q <= quot_d;
  end

  assign stat_o.done = done_q;
  assign stat_o.ovf  = ovf_q;
  assign quot_o      = quot_q;

endmodule

FILE: hdl/skewed_gauss_lattice_reduce.sv
// Top level: sequencer for skewed Gauss-Lagrange reduction of a 2D lattice basis.
//
// Pulse start_i while busy_o is low to hand in one beat of two basis vectors;
// busy_o then stays high until the reduced pair appears for exactly one cycle
// with done_o high, which the receiver must take in that cycle since it cannot
// stall the block. Work is done on one shared 32x32 multiplier and a bit-serial
// divider. Each item first forms both norms, then runs reduction rounds of an
// inner product, a rounding division (one quotient bit per cycle in the divider)
// and an update with the new norm, and ends with a final step; up to MAX_ROUNDS
// rounds are run. The skew weight may be written only while busy_o is low.
module skewed_gauss_lattice_reduce #(
  parameter int unsigned COORD_WIDTH      = 32,
  parameter int unsigned WEIGHT_FRAC_BITS = 12,
  parameter int unsigned MAX_ROUNDS       = 64
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            skew_weight_we_i,
  input  logic [sglr_pkg::WEIGHT_W-1:0]   skew_weight_i,
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic signed [31:0]              first_a_i,
  input  logic signed [31:0]              first_b_i,
  input  logic signed [31:0]              second_a_i,
  input  logic signed [31:0]              second_b_i,
  output logic                            done_o,
  output logic signed [31:0]              long_a_o,
  output logic [30:0]                     long_b_o,
  output logic signed [31:0]              short_a_o,
  output logic [30:0]                     short_b_o,
  output logic                            fault_o
);
  import sglr_pkg::*;

  localparam int unsigned CW   = COORD_WIDTH;
  localparam int unsigned NW   = 2 * CW + 33;
  localparam int unsigned UW   = 2 * CW + 1;
  localparam int unsigned RW   = $clog2(MAX_ROUNDS + 1);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PA,
    ST_PB,
    ST_LO,
    ST_HI,
    ST_ACC,
    ST_ROUND,
    ST_CHECK,
    ST_DIV,
    ST_UPD_A,
    ST_UPD_B,
    ST_UPD_C,
    ST_FINISH
  } state_e;

  typedef enum logic [1:0] {
    T_INIT0,
    T_N0,
    T_N1,
    T_S
  } target_e;

  // Magnitude of a signed coordinate as a multiplier operand.
  function automatic logic [MUL_W-1:0] mag(input logic [CW-1:0] x);
    logic [CW-1:0] u;
    u = x[CW-1] ? (~x + 1'b1) : x;
    return MUL_W'(u);
  endfunction

  state_e               state_q, state_d;
  target_e              tgt_q, tgt_d;
  logic [RW-1:0]        round_q, round_d;
  logic                 fault_q, fault_d;
  logic                 done_q, done_d;
  logic [WEIGHT_W-1:0]  skew_q;

  logic signed [CW-1:0] a0_q, a0_d, b0_q, b0_d, a1_q, a1_d, b1_q, b1_d;
  logic [NW-1:0]        n0_q, n0_d, n1_q, n1_d, s_q, s_d, acc_q, acc_d;
  logic [PROD_W-1:0]    pb_q, pb_d;
  logic                 fs_q, fs_d;
  logic signed [CW-1:0] k_q, k_d;
  logic signed [UW-1:0] na_q, na_d;
  logic signed [31:0]   long_a_q, long_a_d, short_a_q, short_a_d;
  logic [30:0]          long_b_q, long_b_d, short_b_q, short_b_d;

  // Shared unit connections.
  logic [MUL_W-1:0]     mul_a, mul_b;
  logic [PROD_W-1:0]    prod;
  logic                 div_start;
  div_stat_t            div_stat;
  logic signed [CW-1:0] div_quot;

  // Operand selection for the inner product in progress.
  logic signed [CW-1:0] xa, xb, ya, yb;
  logic                 sgn_a, sgn_b;
  logic [NW-1:0]        term;
  logic [NW-1:0]        acc_fin;
  logic                 first_short;
  logic [NW-1:0]        den;
  logic signed [CW-1:0] as, bs, al, bl;
  logic signed [UW-1:0] sp, nb;
  logic                 na_ok, nb_ok;
  logic signed [CW:0]   oa0, ob0, oa1, ob1;
  logic                 nf0, nf1;

  sglr_mul u_mul (
    .clk_i  (clk_i),
    .op_a_i (mul_a),
    .op_b_i (mul_b),
    .prod_o (prod)
  );

  sglr_div #(
    .CW (CW),
    .NW (NW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (s_q),
    .den_i   (den),
    .stat_o  (div_stat),
    .quot_o  (div_quot)
  );

  // Vectors feeding the inner product: a norm uses one vector twice.
  always_comb begin
    case (tgt_q)
      T_N1: begin
        xa = a1_q; xb = b1_q; ya = a1_q; yb = b1_q;
      end
      T_S: begin
        xa = a0_q; xb = b0_q; ya = a1_q; yb = b1_q;
      end
      default: begin
        xa = a0_q; xb = b0_q; ya = a0_q; yb = b0_q;
      end
    endcase
    sgn_a = xa[CW-1] ^ ya[CW-1];
    sgn_b = xb[CW-1] ^ yb[CW-1];
  end

  // Shorter and longer vector of the current round.
  assign first_short = n0_q < n1_q;
  assign den         = first_short ? n0_q : n1_q;
  assign as = fs_q ? a0_q : a1_q;
  assign bs = fs_q ? b0_q : b1_q;
  assign al = fs_q ? a1_q : a0_q;
  assign bl = fs_q ? b1_q : b0_q;

  // Multiplier operand mux.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_PA: begin
        mul_a = mag(xa);
        mul_b = mag(ya);
      end
      ST_PB: begin
        mul_a = mag(xb);
        mul_b = mag(yb);
      end
      ST_LO: begin
        mul_a = prod[MUL_W-1:0];
        mul_b = skew_q;
      end
      ST_HI: begin
        mul_a = pb_q[PROD_W-1:MUL_W];
        mul_b = skew_q;
      end
      ST_UPD_A: begin
        mul_a = mag(k_q);
        mul_b = mag(as);
      end
      ST_UPD_B: begin
        mul_a = mag(k_q);
        mul_b = mag(bs);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Signed multiple of the short vector, and the range check of updates.
  always_comb begin
    if (k_q[CW-1] ^ ((state_q == ST_UPD_B) ? as[CW-1] : bs[CW-1])) begin
      sp = -UW'(prod);
    end else begin
      sp = UW'(prod);
    end
    nb    = UW'(bl) - sp;
    na_ok = (&na_q[UW-1:CW-1]) | ~(|na_q[UW-1:CW-1]);
    nb_ok = (&nb[UW-1:CW-1]) | ~(|nb[UW-1:CW-1]);
  end

  // Final sign normalization: each vector with negative b is negated.
  always_comb begin
    nf0 = 1'b0;
    nf1 = 1'b0;
    if (b0_q[CW-1]) begin
      oa0 = -((CW+1)'(a0_q));
      ob0 = -((CW+1)'(b0_q));
      nf0 = (oa0[CW] != oa0[CW-1]) || (ob0[CW] != ob0[CW-1]);
    end else begin
      oa0 = (CW+1)'(a0_q);
      ob0 = (CW+1)'(b0_q);
    end
    if (b1_q[CW-1]) begin
      oa1 = -((CW+1)'(a1_q));
      ob1 = -((CW+1)'(b1_q));
      nf1 = (oa1[CW] != oa1[CW-1]) || (ob1[CW] != ob1[CW-1]);
    end else begin
      oa1 = (CW+1)'(a1_q);
      ob1 = (CW+1)'(b1_q);
    end
  end

  // Last partial of the skewed term, weighted by two to the multiplier width.
  assign term    = NW'({prod, {MUL_W{1'b0}}});
  assign acc_fin = sgn_b ? (acc_q - term) : (acc_q + term);

  assign div_start = (state_q == ST_CHECK) && (den != '0);

  // Sequencer.
  always_comb begin
    state_d   = state_q;
    tgt_d     = tgt_q;
    round_d   = round_q;
    fault_d   = fault_q;
    done_d    = 1'b0;
    a0_d      = a0_q;
    b0_d      = b0_q;
    a1_d      = a1_q;
    b1_d      = b1_q;
    n0_d      = n0_q;
    n1_d      = n1_q;
    s_d       = s_q;
    acc_d     = acc_q;
    pb_d      = pb_q;
    fs_d      = fs_q;
    k_d       = k_q;
    na_d      = na_q;
    long_a_d  = long_a_q;
    long_b_d  = long_b_q;
    short_a_d = short_a_q;
    short_b_d = short_b_q;

    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          a0_d    = first_a_i[CW-1:0];
          b0_d    = first_b_i[CW-1:0];
          a1_d    = second_a_i[CW-1:0];
          b1_d    = second_b_i[CW-1:0];
          round_d = '0;
          fault_d = 1'b0;
          tgt_d   = T_INIT0;
          state_d = ST_PA;
        end
      end
      ST_PA: begin
        state_d = ST_PB;
      end
      ST_PB: begin
        acc_d   = sgn_a ? -(NW'(prod) << WEIGHT_FRAC_BITS)
                        : (NW'(prod) << WEIGHT_FRAC_BITS);
        state_d = ST_LO;
      end
      ST_LO: begin
        pb_d    = prod;
        state_d = ST_HI;
      end
      ST_HI: begin
        acc_d   = sgn_b ? (acc_q - NW'(prod)) : (acc_q + NW'(prod));
        state_d = ST_ACC;
      end
      ST_ACC: begin
        unique case (tgt_q)
          T_INIT0: begin
            n0_d    = acc_fin;
            tgt_d   = T_N1;
            state_d = ST_PA;
          end
          T_N0: begin
            n0_d    = acc_fin;
            state_d = ST_ROUND;
          end
          T_N1: begin
            n1_d    = acc_fin;
            state_d = ST_ROUND;
          end
          T_S: begin
            s_d     = acc_fin;
            state_d = ST_CHECK;
          end
          default: state_d = ST_ROUND;
        endcase
      end
      ST_ROUND: begin
        if (round_q == RW'(MAX_ROUNDS)) begin
          fault_d = 1'b1;
          state_d = ST_FINISH;
        end else begin
          tgt_d   = T_S;
          state_d = ST_PA;
        end
      end
      ST_CHECK: begin
        fs_d = first_short;
        if (den == '0) begin
          state_d = ST_FINISH;
        end else begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          if (div_stat.ovf) begin
            fault_d = 1'b1;
            state_d = ST_FINISH;
          end else if (div_quot == '0) begin
            state_d = ST_FINISH;
          end else begin
            k_d     = div_quot;
            state_d = ST_UPD_A;
          end
        end
      end
      ST_UPD_A: begin
        state_d = ST_UPD_B;
      end
      ST_UPD_B: begin
        na_d    = UW'(al) - sp;
        state_d = ST_UPD_C;
      end
      ST_UPD_C: begin
        if (na_ok && nb_ok) begin
          if (fs_q) begin
            a1_d  = na_q[CW-1:0];
            b1_d  = nb[CW-1:0];
            tgt_d = T_N1;
          end else begin
            a0_d  = na_q[CW-1:0];
            b0_d  = nb[CW-1:0];
            tgt_d = T_N0;
          end
          round_d = round_q + 1'b1;
          state_d = ST_PA;
        end else begin
          fault_d = 1'b1;
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (n0_q > n1_q) begin
          long_a_d  = 32'(oa0);
          long_b_d  = 31'(ob0);
          short_a_d = 32'(oa1);
          short_b_d = 31'(ob1);
        end else begin
          long_a_d  = 32'(oa1);
          long_b_d  = 31'(ob1);
          short_a_d = 32'(oa0);
          short_b_d = 31'(ob0);
        end
        fault_d = fault_q | nf0 | nf1;
        done_d  = 1'b1;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control state, the skew weight register and the result strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      tgt_q   <= T_INIT0;
      round_q <= '0;
      fault_q <= 1'b0;
      done_q  <= 1'b0;
      skew_q  <= SKEW_RESET;
    end else begin
      state_q <= state_d;
      tgt_q   <= tgt_d;
      round_q <= round_d;
      fault_q <= fault_d;
      done_q  <= done_d;
      if (skew_weight_we_i) begin
        skew_q <= skew_weight_i;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    a0_q      <= a0_d;
    b0_q      <= b0_d;
    a1_q      <= a1_d;
    b1_q      <= b1_d;
    n0_q      <= n0_d;
    n1_q      <= n1_d;
    s_q       <= s_d;
    acc_q     <= acc_d;
    pb_q      <= pb_d;
    fs_q      <= fs_d;
    k_q       <= k_d;
    na_q      <= na_d;
    long_a_q  <= long_a_d;
    long_b_q  <= long_b_d;
    short_a_q <= short_a_d;
    short_b_q <= short_b_d;
  end

  assign busy_o    = state_q != ST_IDLE;
  assign done_o    = done_q;
  assign long_a_o  = long_a_q;
  assign long_b_o  = long_b_q;
  assign short_a_o = short_a_q;
  assign short_b_o = short_b_q;
  assign fault_o   = fault_q;

endmodule

FILE: tb/skewed_gauss_lattice_reduce_test.sv
// Self-checking testbench for the skewed Gauss-Lagrange lattice reduction block.
`timescale 1ns / 1ps

module skewed_gauss_lattice_reduce_test;

  localparam int unsigned NUM_ITEMS  = 1000;
  localparam int unsigned DRAIN_WAIT = 300;
  localparam longint unsigned CYCLE_LIMIT = 40_000_000;

  typedef logic signed [127:0] wide_t;

  // One reduced basis as it leaves the block.
  typedef struct packed {
    logic signed [31:0] long_a;
    logic [30:0]        long_b;
    logic signed [31:0] short_a;
    logic [30:0]        short_b;
    logic               fault;
  } basis_t;

  // Scoreboard: predicts the reduced basis of each accepted beat and checks results.
  class reduction_board;
    logic [sglr_pkg::WEIGHT_W-1:0] weight;
    basis_t expected_q[$];
    int unsigned mismatches;
    int unsigned checked;
    int unsigned faults_seen;

    function new();
      weight      = sglr_pkg::SKEW_RESET;
      mismatches  = 0;
      checked     = 0;
      faults_seen = 0;
    endfunction

    function wide_t skew_dot(wide_t a0, wide_t b0, wide_t a1, wide_t b1);
      wide_t w;
      w = $signed({96'd0, weight});
      return ((a0 * a1) <<< 12) + w * b0 * b1;
    endfunction

    function bit fits(wide_t v);
      return (v >= -(128'sd1 <<< 31)) && (v < (128'sd1 <<< 31));
    endfunction

    // Rounded quotient, ties to even; returns 0 when it leaves the coordinate range.
    function bit round_quot(wide_t s, wide_t d, output wide_t k);
      wide_t mag, q, rem, lim;
      bit neg;
      neg = s < 0;
      mag = neg ? -s : s;
      q   = mag / d;
      rem = mag - q * d;
      if ((rem <<< 1) > d || ((rem <<< 1) == d && q[0])) q = q + 1;
      lim = neg ? (128'sd1 <<< 31) : ((128'sd1 <<< 31) - 1);
      k = neg ? -q : q;
      return q <= lim;
    endfunction

    function void note(logic signed [31:0] fa, logic signed [31:0] fb,
                       logic signed [31:0] sa, logic signed [31:0] sb);
      wide_t a0, b0, a1, b1, n0, n1, s, d, k, na, nb;
      bit fault, finished, first_short;
      basis_t res;
      a0 = fa; b0 = fb; a1 = sa; b1 = sb;
      n0 = skew_dot(a0, b0, a0, b0);
      n1 = skew_dot(a1, b1, a1, b1);
      fault = 0;
      finished = 0;
      for (int r = 0; r < 64 && !finished; r++) begin
        s = skew_dot(a0, b0, a1, b1);
        first_short = n0 < n1;
        d = first_short ? n0 : n1;
        if (d == 0) begin
          finished = 1;
        end else if (!round_quot(s, d, k)) begin
          fault = 1;
          finished = 1;
        end else if (k == 0) begin
          finished = 1;
        end else if (first_short) begin
          na = a1 - k * a0;
          nb = b1 - k * b0;
          if (!fits(na) || !fits(nb)) begin
            fault = 1;
            finished = 1;
          end else begin
            a1 = na; b1 = nb; n1 = skew_dot(a1, b1, a1, b1);
          end
        end else begin
          na = a0 - k * a1;
          nb = b0 - k * b1;
          if (!fits(na) || !fits(nb)) begin
            fault = 1;
            finished = 1;
          end else begin
            a0 = na; b0 = nb; n0 = skew_dot(a0, b0, a0, b0);
          end
        end
      end
      if (!finished) fault = 1;
      // Make b nonnegative; negating the most negative value overflows.
      if (b0 < 0) begin
        b0 = -b0; a0 = -a0;
        if (!fits(a0) || !fits(b0)) fault = 1;
      end
      if (b1 < 0) begin
        b1 = -b1; a1 = -a1;
        if (!fits(a1) || !fits(b1)) fault = 1;
      end
      if (n0 > n1) begin
        res.long_a = a0[31:0]; res.long_b = b0[30:0];
        res.short_a = a1[31:0]; res.short_b = b1[30:0];
      end else begin
        res.long_a = a1[31:0]; res.long_b = b1[30:0];
        res.short_a = a0[31:0]; res.short_b = b0[30:0];
      end
      res.fault = fault;
      expected_q.push_back(res);
    endfunction

    function void check(basis_t got);
      basis_t exp;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected result %p", got);
        return;
      end
      exp = expected_q.pop_front();
      checked++;
      if (got.fault) faults_seen++;
      if (got !== exp) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: result %0d expected %p got %p", checked, exp, got);
      end
    endfunction
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  logic skew_weight_we_i = 0;
  logic [sglr_pkg::WEIGHT_W-1:0] skew_weight_i = '0;
  logic start_i = 0;
  logic busy_o;
  logic signed [31:0] first_a_i = '0, first_b_i = '0, second_a_i = '0, second_b_i = '0;
  logic done_o;
  logic signed [31:0] long_a_o, short_a_o;
  logic [30:0] long_b_o, short_b_o;
  logic fault_o;

  reduction_board board = new();
  longint unsigned cycles = 0;
  int unsigned sent = 0;
  bit no_idle = 0;

  skewed_gauss_lattice_reduce u_dut (
    .clk_i, .rst_ni, .skew_weight_we_i, .skew_weight_i, .start_i, .busy_o,
    .first_a_i, .first_b_i, .second_a_i, .second_b_i,
    .done_o, .long_a_o, .long_b_o, .short_a_o, .short_b_o, .fault_o
  );

  // Clock.
  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  // Result monitor and run limit.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
    if (rst_ni && done_o)
      board.check('{long_a_o, long_b_o, short_a_o, short_b_o, fault_o});
  end

  // Hand in one beat of two basis vectors, after an optional idle burst.
  task automatic send_basis(logic signed [31:0] fa, logic signed [31:0] fb,
                            logic signed [31:0] sa, logic signed [31:0] sb);
    if (!no_idle && $urandom_range(99) < 30) begin
      start_i <= 0;
      repeat ($urandom_range(10, 1)) @(posedge clk_i);
    end
    start_i <= 1;
    first_a_i <= fa; first_b_i <= fb; second_a_i <= sa; second_b_i <= sb;
    do @(posedge clk_i); while (busy_o);
    board.note(fa, fb, sa, sb);
    sent++;
  endtask

  // Let the block drain, then write the skew weight while it is idle.
  task automatic write_weight(logic [sglr_pkg::WEIGHT_W-1:0] w);
    start_i <= 0;
    do @(posedge clk_i); while (board.expected_q.size() != 0 || busy_o);
    repeat (4) @(posedge clk_i);
    skew_weight_we_i <= 1;
    skew_weight_i <= w;
    @(posedge clk_i);
    skew_weight_we_i <= 0;
    board.weight = w;
  endtask

  // Coordinate mix: small, mid-size and full-range values, some extremes and zeros.
  function automatic logic signed [31:0] pick_coord();
    case ($urandom_range(9))
      0, 1, 2: return $signed($urandom_range(200)) - 100;
      3, 4:    return $signed($urandom_range(65535)) - 32768;
      5:       return $signed($urandom_range(3) == 0 ? 32'h8000_0000 : 32'h7fff_ffff);
      6:       return '0;
      default: return $urandom;
    endcase
  endfunction

  task automatic directed_basis();
    send_basis(0, 0, 0, 0);
    send_basis(0, 0, 5, 7);                      // zero divisor
    send_basis(1, 0, 0, 1);                      // equal norms under the reset weight
    send_basis(3, 4, 4, 3);
    send_basis(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000);
    send_basis(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000);
    send_basis(0, 32'h8000_0000, 1, 0);          // negation overflow on b
    send_basis(32'h8000_0000, -1, 0, 1);         // negation overflow on a
    send_basis(1, 1000, 32'h4000_0000, 0);       // coordinate overflow when sigma is 0
    send_basis(1, 1, 32'h8000_0000, 32'h8000_0001);
    send_basis(2, 1, 32'h7fff_ffff, -5);
    send_basis(-1, 0, 32'h8000_0000, 3);
    send_basis(1, 0, 32'h7fff_ffff, 32'h7fff_ffff);
    send_basis(12345, -678, -9876, 4321);
  endtask

  initial begin
    logic [sglr_pkg::WEIGHT_W-1:0] weights[6];
    weights = '{32'd0, 32'hffff_ffff, 32'd1, 32'd0, 32'd4096, 32'd0};
    weights[3] = $urandom;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Directed beats under the reset weight, then with sigma zero.
    directed_basis();
    write_weight(weights[0]);
    directed_basis();

    // Random phases, each with its own weight.
    for (int p = 1; p < 6; p++) begin
      write_weight(weights[p]);
      for (int i = 0; i < NUM_ITEMS / 5; i++) begin
        no_idle = (p == 5) && (i > NUM_ITEMS / 10);
        send_basis(pick_coord(), pick_coord(), pick_coord(), pick_coord());
      end
    end

    start_i <= 0;
    do @(posedge clk_i); while (board.expected_q.size() != 0);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("Covered %0d beats over six weight settings, %0d results with fault set.",
             sent, board.faults_seen);
    $display("Results checked: %0d, mismatches: %0d.", board.checked, board.mismatches);
    if (board.mismatches == 0 && board.expected_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
